[hw/rtl/pifmt_pkg.sv]
// Shared types, codes and helpers for the printf integer formatter.
package pifmt_pkg;

  // Fixed field widths
  localparam int VALUE_W = 64;
  localparam int WIDTH_W = 6;
  localparam int CHAR_W  = 8;

  // Default sizing, overridable on the top level
  localparam int DIGIT_BUFFER_DEF = 24;
  localparam int MAX_WIDTH_DEF    = 63;

  // Decimal digit loop: dividend bits retired per cycle and divide steps per digit
  localparam int DIV_BITS  = 16;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Divide by ten of a (DIV_BITS + 4)-bit step value: (t * DIV_RECIP) >> DIV_SHIFT,
  // exact for t below 2^22
  localparam logic [DIV_BITS+3:0] DIV_RECIP = 20'hCCCCD;
  localparam int                  DIV_SHIFT = 23;

  // Conversion codes
  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEXL = 2'd2;
  localparam logic [1:0] FUNC_HEXU = 2'd3;

  // pad_mode bit positions
  localparam int PAD_LEFT_BIT = 0;
  localparam int PAD_ZERO_BIT = 1;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  // Input beat
  typedef struct packed {
    logic [1:0]               func;
    logic                     long_mode;
    logic signed [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]       field_width;
    logic [1:0]               pad_mode;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic put_zero;
    logic hex_step;
    logic div_step;
    logic sign;
    logic prep;
    logic fill_emit;
    logic text_emit;
    logic last;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic mag_zero;
    logic len_zero;
    logic buf_full;
    logic is_hex;
    logic left;
    logic fill_zero;
    logic fill_one;
    logic tptr_one;
    logic div_last;
  } sts_t;

  // One digit 0..15 to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CH_UPPER_A + {4'd0, d - 4'd10};
    end else begin
      c = CH_LOWER_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

[hw/rtl/pifmt_ctrl.sv]
// Sequencer of the formatter: digit loop, sign handling and character emission.
module pifmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pifmt_pkg::sts_t sts,
  output pifmt_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SIGN  = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_FILLL = 8'b0010_0000,
    S_TEXT  = 8'b0100_0000,
    S_FILLR = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mag_zero || sts.buf_full) begin
          cmd.put_zero = sts.mag_zero && sts.len_zero;
          state_nxt    = S_SIGN;
        end else if (sts.is_hex) begin
          cmd.hex_step = 1'b1;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_CHECK;
      end
      S_SIGN: begin
        cmd.sign  = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.left ? S_TEXT : S_FILLL;
      end
      S_FILLL: begin
        cmd.fill_emit = !sts.fill_zero;
        if (sts.fill_zero || sts.fill_one) state_nxt = S_TEXT;
      end
      S_TEXT: begin
        cmd.text_emit = 1'b1;
        if (sts.tptr_one) begin
          // leading fill is spent by now, so only trailing fill remains
          cmd.last  = sts.fill_zero;
          state_nxt = sts.fill_zero ? S_IDLE : S_FILLR;
        end
      end
      S_FILLR: begin
        cmd.fill_emit = 1'b1;
        cmd.last      = sts.fill_one;
        if (sts.fill_one) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hw/rtl/pifmt_dpath.sv]
// Datapath of the formatter: magnitude, digit divider, text stack and output register.
module pifmt_dpath #(
  parameter int DIGIT_BUFFER = pifmt_pkg::DIGIT_BUFFER_DEF,
  parameter int MAX_WIDTH    = pifmt_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pifmt_pkg::in_t  in_item,
  input  pifmt_pkg::cmd_t cmd,
  output pifmt_pkg::sts_t sts,
  output logic            out_valid,
  output pifmt_pkg::out_t out_item
);

  localparam int IDX_W = $clog2(DIGIT_BUFFER);
  localparam int LEN_W = $clog2(DIGIT_BUFFER + 1);
  localparam int VW    = pifmt_pkg::VALUE_W;
  localparam int WW    = pifmt_pkg::WIDTH_W;
  localparam int CW    = pifmt_pkg::CHAR_W;
  localparam int SW    = pifmt_pkg::STEP_W;
  localparam int DB    = pifmt_pkg::DIV_BITS;
  localparam int DT_W  = DB + 4;

  // Item registers
  logic [1:0]    func_r,  func_nxt;
  logic          left_r,  left_nxt;
  logic          zero_r,  zero_nxt;
  logic          neg_r,   neg_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [VW-1:0] mag_r,   mag_nxt;
  logic [3:0]    rem_r,   rem_nxt;
  logic [SW-1:0] step_r,  step_nxt;
  logic [LEN_W-1:0] len_r,  len_nxt;
  logic [LEN_W-1:0] tptr_r, tptr_nxt;
  logic [WW-1:0] fill_r,  fill_nxt;
  logic          ov_r,    ov_nxt;
  pifmt_pkg::out_t oi_r, oi_nxt;

  // Text stack, least significant character at index 0
  logic [CW-1:0]    txt_r [DIGIT_BUFFER];
  logic             wr_en;
  logic [CW-1:0]    wr_char;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  // Load-time extension and magnitude
  logic [VW-1:0] ext_v;
  logic          ext_neg;
  logic [31:0]   low_w;

  // Divider step results
  logic [3:0]        dv_rem;
  logic [VW-1:0]     dv_mag;
  logic [DT_W-1:0]   dv_t;
  logic [2*DT_W-1:0] dv_p;
  logic [DB-1:0]     dv_q;
  logic [DT_W-1:0]   dv_d;

  logic [CW-1:0] fill_ch;
  logic [WW:0]   width_x, len_x;

  always_comb begin
    low_w = in_item.value[31:0];
    if (in_item.long_mode) begin
      ext_v = in_item.value;
    end else if ((in_item.func == pifmt_pkg::FUNC_SDEC) && low_w[31]) begin
      ext_v = {32'hFFFF_FFFF, low_w};
    end else begin
      ext_v = {32'd0, low_w};
    end
    ext_neg = (in_item.func == pifmt_pkg::FUNC_SDEC) && ext_v[VW-1];
  end

  // One long-division-by-ten step on the top chunk: reciprocal multiply gives the
  // quotient chunk, multiply back and subtract gives the running remainder
  always_comb begin
    dv_t   = {rem_r, mag_r[VW-1 -: DB]};
    dv_p   = {{DT_W{1'b0}}, dv_t} * {{DT_W{1'b0}}, pifmt_pkg::DIV_RECIP};
    dv_q   = dv_p[pifmt_pkg::DIV_SHIFT +: DB];
    dv_d   = dv_t - ({1'b0, dv_q, 3'd0} + {3'd0, dv_q, 1'b0});
    dv_rem = dv_d[3:0];
    dv_mag = {mag_r[VW-DB-1:0], dv_q};
  end

  assign fill_ch = zero_r ? pifmt_pkg::CH_ZERO : pifmt_pkg::CH_SPACE;
  assign width_x = {1'b0, width_r};
  assign len_x   = (WW + 1)'(len_r);
  assign wr_idx  = len_r[IDX_W-1:0];
  assign rd_idx  = IDX_W'(tptr_r - LEN_W'(1));

  // Next-value logic
  always_comb begin
    func_nxt  = func_r;
    left_nxt  = left_r;
    zero_nxt  = zero_r;
    neg_nxt   = neg_r;
    width_nxt = width_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    len_nxt   = len_r;
    tptr_nxt  = tptr_r;
    fill_nxt  = fill_r;
    ov_nxt    = 1'b0;
    oi_nxt    = oi_r;
    wr_en     = 1'b0;
    wr_char   = pifmt_pkg::CH_ZERO;

    if (cmd.load) begin
      func_nxt  = in_item.func;
      left_nxt  = in_item.pad_mode[pifmt_pkg::PAD_LEFT_BIT];
      zero_nxt  = in_item.pad_mode[pifmt_pkg::PAD_ZERO_BIT];
      neg_nxt   = ext_neg;
      width_nxt = (in_item.field_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                         : in_item.field_width;
      mag_nxt   = ext_neg ? (~ext_v + 1'b1) : ext_v;
      rem_nxt   = '0;
      step_nxt  = '0;
      len_nxt   = '0;
    end

    if (cmd.put_zero) begin
      wr_en   = 1'b1;
      wr_char = pifmt_pkg::CH_ZERO;
      len_nxt = len_r + 1'b1;
    end

    // Hex digit: low nibble out, shift right
    if (cmd.hex_step) begin
      wr_en   = 1'b1;
      wr_char = pifmt_pkg::digit_char(mag_r[3:0], func_r == pifmt_pkg::FUNC_HEXU);
      mag_nxt = {4'd0, mag_r[VW-1:4]};
      len_nxt = len_r + 1'b1;
    end

    // Decimal digit: remainder is complete on the last step
    if (cmd.div_step) begin
      mag_nxt  = dv_mag;
      step_nxt = step_r + 1'b1;
      if (sts.div_last) begin
        wr_en   = 1'b1;
        wr_char = pifmt_pkg::digit_char(dv_rem, 1'b0);
        len_nxt = len_r + 1'b1;
        rem_nxt = '0;
      end else begin
        rem_nxt = dv_rem;
      end
    end

    // Sign: leading beat with zero fill and a width, else part of the text
    if (cmd.sign && neg_r) begin
      if ((width_r != '0) && zero_r) begin
        ov_nxt          = 1'b1;
        oi_nxt.out_char = pifmt_pkg::CH_MINUS;
        oi_nxt.last     = 1'b0;
        width_nxt       = width_r - 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_char = pifmt_pkg::CH_MINUS;
        len_nxt = len_r + 1'b1;
      end
    end

    if (cmd.prep) begin
      fill_nxt = (width_x > len_x) ? WW'(width_x - len_x) : '0;
      tptr_nxt = len_r;
    end

    if (cmd.fill_emit) begin
      ov_nxt          = 1'b1;
      oi_nxt.out_char = fill_ch;
      oi_nxt.last     = cmd.last;
      fill_nxt        = fill_r - 1'b1;
    end

    // Text beat: the character itself is read from the stack in the register block
    if (cmd.text_emit) begin
      ov_nxt   = 1'b1;
      tptr_nxt = tptr_r - 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    sts.mag_zero  = (mag_r == '0);
    sts.len_zero  = (len_r == '0);
    sts.buf_full  = (len_r == LEN_W'(DIGIT_BUFFER - 1));
    sts.is_hex    = (func_r == pifmt_pkg::FUNC_HEXL) || (func_r == pifmt_pkg::FUNC_HEXU);
    sts.left      = left_r;
    sts.fill_zero = (fill_r == '0);
    sts.fill_one  = (fill_r == WW'(1));
    sts.tptr_one  = (tptr_r == LEN_W'(1));
    sts.div_last  = (step_r == SW'(pifmt_pkg::DIV_STEPS - 1));
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    left_r  <= left_nxt;
    zero_r  <= zero_nxt;
    neg_r   <= neg_nxt;
    width_r <= width_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    len_r   <= len_nxt;
    tptr_r  <= tptr_nxt;
    fill_r  <= fill_nxt;
    if (cmd.text_emit) begin
      oi_r <= pifmt_pkg::out_t'{txt_r[rd_idx], cmd.last};
    end else begin
      oi_r <= oi_nxt;
    end
    if (wr_en) txt_r[wr_idx] <= wr_char;
  end

  // Output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule

[hw/rtl/printf_integer_formatter.sv]
// Top level of the printf integer formatter: controller plus datapath.
//
//  channel  ports                       handshake
//  input    in_item (in_t)              accepted when start && !busy
//  result   out_item (out_t)            one beat per cycle out_valid is high
//
// After the accepting edge: a check plus 4 steps of the 16-bit divide-by-ten loop per
// decimal digit or a check per hex digit, a closing check, sign and fill setup, one
// beat per character, an idle step when right-justified text has no fill; the final
// beat shows in the same cycle that busy drops.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The receiver cannot stall: each beat shows for exactly one cycle.
module printf_integer_formatter #(
  parameter int DIGIT_BUFFER = pifmt_pkg::DIGIT_BUFFER_DEF,
  parameter int MAX_WIDTH    = pifmt_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pifmt_pkg::in_t  in_item,
  output logic            out_valid,
  output pifmt_pkg::out_t out_item
);

  pifmt_pkg::cmd_t cmd;
  pifmt_pkg::sts_t sts;

  pifmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pifmt_dpath #(
    .DIGIT_BUFFER (DIGIT_BUFFER),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A beat that is not the last comes while the item is still in work
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("non-final beat after the item finished");

  // Nothing follows the final beat directly
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("beat directly after the final beat");

  // A new item starts with no beat pending
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("beat at the start of a new item");

endmodule

[tb/printf_integer_formatter_tb.sv]
// Self-checking testbench for the printf integer formatter: predicts every character beat.
`timescale 1ns / 1ps

module printf_integer_formatter_tb;

  localparam logic [1:0] PAD_NONE = 2'b00;
  localparam logic [1:0] PAD_LEFT = 2'(1 << pifmt_pkg::PAD_LEFT_BIT);
  localparam logic [1:0] PAD_ZERO = 2'(1 << pifmt_pkg::PAD_ZERO_BIT);
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int TAIL_CYCLES = 500;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pifmt_pkg::in_t  in_item = '0;
  logic out_valid;
  pifmt_pkg::out_t out_item;

  pifmt_pkg::in_t  pending [$];     // conversions waiting to be issued
  pifmt_pkg::out_t exp_chars [$];   // predicted character beats, oldest first
  int   gap_left = 0;
  int   issued = 0;
  int   fail_count = 0;

  printf_integer_formatter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected characters of one conversion, appended to exp_chars
  function automatic void format_chars(input pifmt_pkg::in_t it);
    logic [63:0] v;
    logic [63:0] mag;
    logic [7:0]  text [$];
    logic [7:0]  fill_ch;
    logic [7:0]  alpha;
    logic [7:0]  ch;
    logic [3:0]  d;
    logic        neg;
    logic        left;
    logic        zfill;
    int          w;
    int          base;
    int          fill;
    v = it.value;
    w = it.field_width;
    if (w > pifmt_pkg::MAX_WIDTH_DEF) w = pifmt_pkg::MAX_WIDTH_DEF;
    left = it.pad_mode[pifmt_pkg::PAD_LEFT_BIT];
    zfill = it.pad_mode[pifmt_pkg::PAD_ZERO_BIT];
    fill_ch = zfill ? pifmt_pkg::CH_ZERO : pifmt_pkg::CH_SPACE;
    alpha = (it.func == pifmt_pkg::FUNC_HEXU) ? pifmt_pkg::CH_UPPER_A : pifmt_pkg::CH_LOWER_A;
    base = (it.func == pifmt_pkg::FUNC_HEXL || it.func == pifmt_pkg::FUNC_HEXU) ? 16 : 10;
    // 32-bit mode: sign-extend for signed decimal only
    if (!it.long_mode) begin
      v = (it.func == pifmt_pkg::FUNC_SDEC) ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
    end
    neg = (it.func == pifmt_pkg::FUNC_SDEC) && v[63];
    mag = neg ? -v : v;
    // digits, least significant first
    if (mag == 64'd0) text.push_back(pifmt_pkg::CH_ZERO);
    while (mag != 64'd0 && text.size() < pifmt_pkg::DIGIT_BUFFER_DEF - 1) begin
      d = 4'(mag % 64'(base));
      if (d < 4'd10) begin
        ch = 8'(pifmt_pkg::CH_ZERO + d);
      end else begin
        ch = 8'(alpha + (d - 4'd10));
      end
      text.push_back(ch);
      mag = mag / 64'(base);
    end
    // zero fill with a width puts the sign ahead of the fill
    if (neg) begin
      if (w != 0 && zfill) begin
        exp_chars.push_back(pifmt_pkg::out_t'{pifmt_pkg::CH_MINUS, 1'b0});
        w--;
      end else begin
        text.push_back(pifmt_pkg::CH_MINUS);
      end
    end
    fill = (w > text.size()) ? w - text.size() : 0;
    if (!left) repeat (fill) exp_chars.push_back(pifmt_pkg::out_t'{fill_ch, 1'b0});
    for (int i = text.size() - 1; i >= 0; i--) begin
      exp_chars.push_back(pifmt_pkg::out_t'{text[i], 1'b0});
    end
    if (left) repeat (fill) exp_chars.push_back(pifmt_pkg::out_t'{fill_ch, 1'b0});
    exp_chars[exp_chars.size() - 1].last = 1'b1;
  endfunction

  // Idle gap before the next conversion: mostly short, a few long, a burst with none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (issued >= 40 && issued < 60) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_item(input logic [1:0] func, input logic long_mode,
                          input logic [63:0] value, input logic [5:0] fw,
                          input logic [1:0] pad);
    pending.push_back(pifmt_pkg::in_t'{func, long_mode, value, fw, pad});
  endtask

  // Driver: present the head of the pending queue, retire it on accept
  always @(posedge clk) begin : drive
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        format_chars(in_item);
        void'(pending.pop_front());
        issued++;
        go = 1'b0;
        gap_left = pick_gap();
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          go = 1'b1;
          in_item <= pending[0];
        end
      end
      start <= go;
    end
  end

  // Monitor: each strobed beat against the oldest prediction
  always @(posedge clk) begin : watch
    pifmt_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got char %h last %b",
                 $time, out_item.out_char, out_item.last);
        fail_count++;
      end else begin
        want = exp_chars.pop_front();
        if (out_item.out_char !== want.out_char) begin
          $display("%0t: out_char mismatch, expected %h got %h",
                   $time, want.out_char, out_item.out_char);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $display("%0t: last mismatch, expected %b got %b", $time, want.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim
    logic [63:0] raw;
    logic [63:0] val;
    int          fw;
    // zero, sign and extremes in 64-bit mode
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, 64'd0, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, '1, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, MIN_S64, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, MAX_S64, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_UDEC, 1'b1, '1, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_HEXL, 1'b1, '1, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_HEXU, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 6'd0, PAD_NONE);
    // 32-bit mode: upper word ignored, sign from bit 31 only for signed decimal
    add_item(pifmt_pkg::FUNC_SDEC, 1'b0, 64'h1234_5678_8000_0000, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_UDEC, 1'b0, 64'hA5A5_A5A5_FFFF_FFFF, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b0, 64'hFFFF_FFFF_7FFF_FFFF, 6'd0, PAD_NONE);
    add_item(pifmt_pkg::FUNC_HEXU, 1'b0, 64'hFFFF_FFFF_0000_0000, 6'd4, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b0, 64'hFFFF_FFFF_0000_0000, 6'd0, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_HEXL, 1'b0, 64'hFFFF_FFFF_ABCD_EF01, 6'd0, PAD_NONE);
    // negative with zero fill: with a width the sign leads and takes one column
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd8, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd8, PAD_ZERO | PAD_LEFT);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd1, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd0, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, MIN_S64, 6'd63, PAD_ZERO | PAD_LEFT);
    // negative with space fill: sign sticks to the digits
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd8, PAD_NONE);
    add_item(pifmt_pkg::FUNC_SDEC, 1'b1, -64'sd42, 6'd8, PAD_LEFT);
    // widest field, text wider than field, zero with a width
    add_item(pifmt_pkg::FUNC_UDEC, 1'b1, 64'd42, 6'd63, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_HEXU, 1'b1, 64'd42, 6'd63, PAD_LEFT);
    add_item(pifmt_pkg::FUNC_UDEC, 1'b1, '1, 6'd5, PAD_ZERO);
    add_item(pifmt_pkg::FUNC_HEXL, 1'b1, 64'hAB, 6'd10, PAD_ZERO | PAD_LEFT);
    add_item(pifmt_pkg::FUNC_UDEC, 1'b0, 64'd0, 6'd5, PAD_NONE);

    // random conversions with assorted magnitudes
    repeat (75) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: val = raw;
        1: val = raw >> $urandom_range(1, 63);
        2: val = -(raw >> $urandom_range(1, 63));
        default: val = {raw[63], {63{raw[62]}}};
      endcase
      fw = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 63) : $urandom_range(0, 24);
      add_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), val, 6'(fw),
               2'($urandom_range(0, 3)));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending.size() != 0 || start || exp_chars.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_chars.size() != 0) begin
      $display("%0t: %0d predicted beats never arrived", $time, exp_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[printf_integer_formatter] OK");
    end else begin
      $display("[printf_integer_formatter] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[printf_integer_formatter] ERROR");
    $finish;
  end

endmodule
